// ----- src/chs_pkg.sv -----
// Shared constants for the coordinate hash set: operation and outcome codes, configuration indexes, mix constants.
package chs_pkg;

    // operation codes
    localparam logic [1:0] OP_CONTAINS = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // outcome codes
    localparam logic [2:0] RES_ABSENT   = 3'd0;
    localparam logic [2:0] RES_PRESENT  = 3'd1;
    localparam logic [2:0] RES_INSERTED = 3'd2;
    localparam logic [2:0] RES_REJECTED = 3'd3;
    localparam logic [2:0] RES_CLEARED  = 3'd4;

    // configuration register indexes
    localparam logic CFG_DIMENSION  = 1'b0;
    localparam logic CFG_ITEM_LIMIT = 1'b1;

    // splitmix64 constants and key salts
    localparam logic [63:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2    = 64'h94d049bb133111eb;
    localparam logic [63:0] HASH_SEED = 64'h243f6a8885a308d3;
    localparam logic [63:0] SALT_X    = 64'h000000009e3779b9;
    localparam logic [63:0] SALT_Y    = 64'h00000000bf58476d;
    localparam logic [63:0] SALT_Z    = 64'h0000000094d049bb;
    localparam logic [63:0] DIM_MUL   = 64'h632be59bd9b4e019;

    localparam logic [31:0] GEN_TOP   = 32'hFFFFFFFF;

endpackage

// ----- src/chs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/chs_mul64.sv -----
// Low 64 bits of a 64x64 product from one 32x32 multiplier: lo*lo, lo*hi, hi*lo, then the sum.
module chs_mul64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [1:0]  r_phase;
    logic        r_done;
    logic [63:0] r_acc;
    logic [31:0] r_x1;
    logic [31:0] r_x2;
    logic [63:0] r_prod;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // operand select per phase: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_phase)
            2'd1: begin
                mul_a = i_a[31:0];
                mul_b = i_b[63:32];
            end
            2'd2: begin
                mul_a = i_a[63:32];
                mul_b = i_b[31:0];
            end
            default: begin
                mul_a = i_a[31:0];
                mul_b = i_b[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // phase control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                2'd0: begin
                    if (i_start) begin
                        r_phase <= 2'd1;
                    end
                end
                2'd1: r_phase <= 2'd2;
                2'd2: r_phase <= 2'd3;
                default: begin
                    r_phase <= 2'd0;
                    r_done  <= 1'b1;
                end
            endcase
        end
    end

    // partial products and final sum
    always_ff @(posedge i_clk) begin
        case (r_phase)
            2'd0: r_acc <= mul_p;
            2'd1: r_x1  <= mul_p[31:0];
            2'd2: r_x2  <= mul_p[31:0];
            default: r_prod <= r_acc + {r_x1 + r_x2, 32'b0};
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- src/coordinate_hash_set_unit.sv -----
// Top level of the coordinate hash set: hash sequencer, probe loop and slot tables.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | i_in_valid/o_in_stall| i_operation, i_coord_x/y/z
//  out     | output    | o_out_valid/i_out_stall | o_outcome, o_item_count
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A contains or insert runs the hash (seven splitmix rounds, each with two 64-bit
// products through the one shared 32x32 multiplier, the dimension round a third), then
// a remainder when TABLE_SLOTS is not a power of two (high-word folds and a
// reciprocal estimate on the same multiplier), then per probed slot a registered RAM
// read and a compare. Clear goes straight to the output state.
// After reset, and after a clear at the top generation, a sweep zeroes every stamp
// while no request is accepted. A stalled result holds the sequencer in its output
// state; one request is in work at a time.
module coordinate_hash_set_unit
    import chs_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_outcome,
    output logic [11:0]        o_item_count,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_data
);

    localparam int  SW      = $clog2(TABLE_SLOTS);
    localparam int  PW      = $clog2(TABLE_SLOTS + 1);
    localparam bit  IS_POW2 = ((1 << SW) == TABLE_SLOTS);
    // 2^32 mod TABLE_SLOTS for folding, floor(2^32 / TABLE_SLOTS) for the quotient
    localparam logic [63:0] FOLD_MUL = 64'((64'd1 << 32) % 64'(TABLE_SLOTS));
    localparam logic [63:0] RECIP    = 64'((64'd1 << 32) / 64'(TABLE_SLOTS));

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE, S_LOAD, S_DMUL, S_ADD, S_XS1, S_MUL1, S_XS2, S_MUL2,
        S_XS3, S_MOD, S_FMUL, S_QMUL, S_NMUL, S_FIX, S_PRD, S_PCHK, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_stage, n_stage;
    logic [1:0]  r_op, n_op;
    logic [31:0] r_kx, n_kx;
    logic [31:0] r_ky, n_ky;
    logic [31:0] r_kz, n_kz;
    logic [63:0] r_h, n_h;
    logic [63:0] r_v, n_v;
    logic [SW-1:0] r_slot, n_slot;
    logic [PW-1:0] r_probe, n_probe;
    logic [31:0] r_gen, n_gen;
    logic [11:0] r_count, n_count;
    logic [1:0]  r_dim, n_dim;
    logic [11:0] r_limit, n_limit;
    logic        r_mul_go, n_mul_go;
    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_outcome, n_outcome;
    logic [11:0] r_ocount, n_ocount;
    logic [2:0]  r_res, n_res;
    logic        r_wrap, n_wrap;

    logic          stamp_we;
    logic [31:0]   stamp_wdata;
    logic [31:0]   stamp_rdata;
    logic          key_we;
    logic [95:0]   key_rdata;
    logic [63:0]   mul_a;
    logic [63:0]   mul_b;
    logic          mul_done;
    logic [63:0]   mul_prod;
    logic [63:0]   mix_out;
    logic [SW-1:0] slot_next;

    // shared multiplier operands follow the sequencer state
    always_comb begin
        case (r_state)
            S_DMUL: begin
                mul_a = {62'b0, r_dim};
                mul_b = DIM_MUL;
            end
            S_MUL2: begin
                mul_a = r_v;
                mul_b = MIX_M2;
            end
            S_FMUL: begin
                mul_a = {32'b0, r_v[63:32]};
                mul_b = FOLD_MUL;
            end
            S_QMUL: begin
                mul_a = r_v;
                mul_b = RECIP;
            end
            S_NMUL: begin
                mul_a = r_v;
                mul_b = 64'(TABLE_SLOTS);
            end
            default: begin
                mul_a = r_v;
                mul_b = MIX_M1;
            end
        endcase
    end

    chs_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // slot tables: stamps and packed keys
    chs_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_slot),
        .i_wdata (stamp_wdata),
        .i_raddr (r_slot),
        .o_rdata (stamp_rdata)
    );

    chs_ram #(.WIDTH(96), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_slot),
        .i_wdata ({r_kx, r_ky, r_kz}),
        .i_raddr (r_slot),
        .o_rdata (key_rdata)
    );

    assign mix_out   = r_v ^ (r_v >> 31);
    assign slot_next = (r_slot == SW'(TABLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_stage   = r_stage;
        n_op      = r_op;
        n_kx      = r_kx;
        n_ky      = r_ky;
        n_kz      = r_kz;
        n_h       = r_h;
        n_v       = r_v;
        n_slot    = r_slot;
        n_probe   = r_probe;
        n_gen     = r_gen;
        n_count   = r_count;
        n_dim     = r_dim;
        n_limit   = r_limit;
        n_mul_go  = 1'b0;
        n_ovalid  = r_ovalid && i_out_stall;
        n_outcome = r_outcome;
        n_ocount  = r_ocount;
        n_res     = r_res;
        n_wrap    = r_wrap;
        stamp_we    = 1'b0;
        stamp_wdata = r_gen;
        key_we      = 1'b0;

        // configuration writes land in any state
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIMENSION:  n_dim   = i_cfg_data[1:0];
                default:        n_limit = i_cfg_data;
            endcase
        end

        case (r_state)
            S_SWEEP: begin
                stamp_we    = 1'b1;
                stamp_wdata = '0;
                if (r_slot == SW'(TABLE_SLOTS - 1)) begin
                    n_slot  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_operation;
                    n_kx = i_coord_x;
                    n_ky = i_coord_y;
                    n_kz = i_coord_z;
                    n_wrap = 1'b0;
                    if (i_operation == OP_CLEAR) begin
                        if (r_gen == GEN_TOP) begin
                            n_gen  = 32'd1;
                            n_wrap = 1'b1;
                        end else begin
                            n_gen = r_gen + 32'd1;
                        end
                        n_count = '0;
                        n_res   = RES_CLEARED;
                        n_state = S_OUT;
                    end else if (i_operation == OP_INSERT && r_count >= r_limit) begin
                        n_res   = RES_REJECTED;
                        n_state = S_OUT;
                    end else if (i_operation == OP_INSERT ||
                                 i_operation == OP_CONTAINS) begin
                        n_res   = (i_operation == OP_INSERT) ? RES_REJECTED : RES_ABSENT;
                        n_h     = HASH_SEED;
                        n_stage = 3'd0;
                        n_state = S_LOAD;
                    end else begin
                        n_res   = RES_ABSENT;
                        n_state = S_OUT;
                    end
                end
            end
            // pick the value for this mix round
            S_LOAD: begin
                n_state = S_ADD;
                case (r_stage)
                    3'd0: n_v = {32'b0, r_kx} ^ SALT_X;
                    3'd2: n_v = {31'b0, r_ky, 1'b0} ^ SALT_Y;
                    3'd4: n_v = {30'b0, r_kz, 2'b0} ^ SALT_Z;
                    3'd5: begin
                        n_mul_go = 1'b1;
                        n_state  = S_DMUL;
                    end
                    default: n_v = r_h;
                endcase
            end
            S_DMUL: begin
                if (mul_done) begin
                    n_v     = mul_prod;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_v     = r_v + MIX_ADD;
                n_state = S_XS1;
            end
            S_XS1: begin
                n_v      = r_v ^ (r_v >> 30);
                n_mul_go = 1'b1;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                if (mul_done) begin
                    n_v     = mul_prod;
                    n_state = S_XS2;
                end
            end
            S_XS2: begin
                n_v      = r_v ^ (r_v >> 27);
                n_mul_go = 1'b1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                if (mul_done) begin
                    n_v     = mul_prod;
                    n_state = S_XS3;
                end
            end
            // finish the round: fold into the running hash or replace it
            S_XS3: begin
                if (r_stage == 3'd0 || r_stage == 3'd2 || r_stage == 3'd4 ||
                    r_stage == 3'd5) begin
                    n_h = r_h ^ mix_out;
                end else begin
                    n_h = mix_out;
                end
                if (r_stage == 3'd6) begin
                    n_probe = '0;
                    if (IS_POW2) begin
                        n_slot  = mix_out[SW-1:0];
                        n_state = S_PRD;
                    end else begin
                        n_v     = mix_out;
                        n_state = S_MOD;
                    end
                end else begin
                    n_stage = r_stage + 3'd1;
                    n_state = S_LOAD;
                end
            end
            // fold the high word back in until the value fits in 32 bits
            S_MOD: begin
                n_mul_go = 1'b1;
                if (r_v[63:32] != 32'd0) begin
                    n_h     = {32'b0, r_v[31:0]};
                    n_state = S_FMUL;
                end else begin
                    n_state = S_QMUL;
                end
            end
            S_FMUL: begin
                if (mul_done) begin
                    n_v     = mul_prod + r_h;
                    n_state = S_MOD;
                end
            end
            // quotient estimate, low by at most one
            S_QMUL: begin
                if (mul_done) begin
                    n_h      = r_v;
                    n_v      = {32'b0, mul_prod[63:32]};
                    n_mul_go = 1'b1;
                    n_state  = S_NMUL;
                end
            end
            S_NMUL: begin
                if (mul_done) begin
                    n_v     = r_h - mul_prod;
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (r_v >= 64'(TABLE_SLOTS)) begin
                    n_v = r_v - 64'(TABLE_SLOTS);
                end else begin
                    n_slot  = r_v[SW-1:0];
                    n_state = S_PRD;
                end
            end
            S_PRD: n_state = S_PCHK;
            // probe: empty slot ends the walk, matching key ends it, else step on until every slot is probed
            S_PCHK: begin
                if (stamp_rdata != r_gen) begin
                    if (r_op == OP_INSERT) begin
                        stamp_we = 1'b1;
                        key_we   = 1'b1;
                        n_count  = r_count + 12'd1;
                        n_res    = RES_INSERTED;
                    end
                    n_state = S_OUT;
                end else if (key_rdata == {r_kx, r_ky, r_kz}) begin
                    n_res   = RES_PRESENT;
                    n_state = S_OUT;
                end else if (r_probe == PW'(TABLE_SLOTS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_slot  = slot_next;
                    n_probe = r_probe + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid  = 1'b1;
                    n_outcome = r_res;
                    n_ocount  = r_count;
                    if (r_wrap) begin
                        n_slot  = '0;
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_slot   <= '0;
            r_gen    <= 32'd1;
            r_count  <= '0;
            r_dim    <= 2'd2;
            r_limit  <= 12'd3072;
            r_mul_go <= 1'b0;
            r_ovalid <= 1'b0;
            r_wrap   <= 1'b0;
            r_stage  <= '0;
            r_probe  <= '0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_gen    <= n_gen;
            r_count  <= n_count;
            r_dim    <= n_dim;
            r_limit  <= n_limit;
            r_mul_go <= n_mul_go;
            r_ovalid <= n_ovalid;
            r_wrap   <= n_wrap;
            r_stage  <= n_stage;
            r_probe  <= n_probe;
        end
        r_op      <= n_op;
        r_kx      <= n_kx;
        r_ky      <= n_ky;
        r_kz      <= n_kz;
        r_h       <= n_h;
        r_v       <= n_v;
        r_outcome <= n_outcome;
        r_ocount  <= n_ocount;
        r_res     <= n_res;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_outcome    = r_outcome;
    assign o_item_count = r_ocount;

endmodule
